[rtl/combination_rank_to_pattern_assert.svh]
// assertion macros for the combination rank to pattern block
// used by the port checker; expects clk and arst_n in scope
`ifndef COMBINATION_RANK_TO_PATTERN_ASSERT_SVH
`define COMBINATION_RANK_TO_PATTERN_ASSERT_SVH

// same-cycle implication
`define CRP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crp check failed");

// next-cycle implication
`define CRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crp check failed");

`endif

[rtl/crp_pkg.sv]
// shared constants, types and helper functions of the combination rank to pattern block
// no dependencies
package crp_pkg;

	localparam int MAX_LENGTH = 64;
	localparam int IDX_W      = $clog2(MAX_LENGTH);
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int DEPTH      = MAX_LENGTH * MAX_LENGTH;
	localparam int CNT_W      = 7;
	localparam int RANK_W     = 63;
	localparam int PAT_W      = 64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FILL
	} state_t;

	typedef enum logic [1:0] {
		INIT_RD,
		INIT_WR,
		INIT_DONE
	} init_state_t;

	// table address of C(a+b-1, a-1): row a+b-1, column a-1
	function automatic logic [ADDR_W-1:0] binom_addr(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
		row = a + b - CNT_W'(1);
		col = a - CNT_W'(1);
		return {row[IDX_W-1:0], col[IDX_W-1:0]};
	endfunction

	// bits below n set
	function automatic logic [PAT_W-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [PAT_W-1:0] m;
		for (int i = 0; i < PAT_W; i++) begin
			m[i] = (CNT_W'(i) < n);
		end
		return m;
	endfunction

endpackage

[rtl/crp_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module crp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/crp_table.sv]
// pascal table of binomial coefficients, built row by row into a ram after reset
// depends on crp_pkg and crp_ram
module crp_table (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [crp_pkg::ADDR_W-1:0] lookup_addr,
	output logic [crp_pkg::PAT_W-1:0]  lookup_data,
	output logic                       table_ready
);

	crp_pkg::init_state_t state_q, state_d;
	logic [crp_pkg::IDX_W-1:0] n_q;
	logic [crp_pkg::IDX_W-1:0] r_q;
	logic [crp_pkg::PAT_W-1:0] left_q;

	logic                       we;
	logic [crp_pkg::ADDR_W-1:0] waddr;
	logic [crp_pkg::PAT_W-1:0]  wdata;
	logic [crp_pkg::ADDR_W-1:0] raddr;
	logic [crp_pkg::PAT_W-1:0]  rdata;
	logic [crp_pkg::IDX_W-1:0]  n_prev;
	logic                       row_end;
	logic                       last_entry;

	assign n_prev     = n_q - crp_pkg::IDX_W'(1);
	assign row_end    = (r_q == n_q);
	assign last_entry = row_end && (n_q == {crp_pkg::IDX_W{1'b1}});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crp_pkg::INIT_RD: begin
				state_d = crp_pkg::INIT_WR;
			end
			crp_pkg::INIT_WR: begin
				state_d = last_entry ? crp_pkg::INIT_DONE : crp_pkg::INIT_RD;
			end
			crp_pkg::INIT_DONE: begin
				state_d = crp_pkg::INIT_DONE;
			end
			default: begin
				state_d = crp_pkg::INIT_RD;
			end
		endcase
	end

	// outputs
	always_comb begin
		we          = 1'b0;
		waddr       = {n_q, r_q};
		wdata       = '0;
		raddr       = {n_prev, r_q};
		table_ready = 1'b0;
		unique case (state_q)
			crp_pkg::INIT_RD: begin
				raddr = {n_prev, r_q};
			end
			crp_pkg::INIT_WR: begin
				we = 1'b1;
				if (n_q == '0) begin
					wdata = crp_pkg::PAT_W'(1);
				end else begin
					wdata = left_q + (row_end ? '0 : rdata);
				end
			end
			crp_pkg::INIT_DONE: begin
				raddr       = lookup_addr;
				table_ready = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crp_pkg::INIT_RD;
			n_q     <= '0;
			r_q     <= '0;
			left_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == crp_pkg::INIT_WR) begin
				if (row_end) begin
					n_q    <= n_q + crp_pkg::IDX_W'(1);
					r_q    <= '0;
					left_q <= '0;
				end else begin
					r_q    <= r_q + crp_pkg::IDX_W'(1);
					left_q <= rdata;
				end
			end
		end
	end

	crp_ram #(
		.WIDTH(crp_pkg::PAT_W),
		.DEPTH(crp_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign lookup_data = rdata;

endmodule

[rtl/combination_rank_to_pattern.sv]
// top level of the lexicographic combination unranking block
// depends on crp_pkg and crp_table
//
//  channel | handshake            | payload
//  in      | in_valid, in_ready   | count_a, count_b, rank
//  out     | out_valid, out_ready | pattern, length, too_long
//
// one symbol per cycle while both counts remain, set by the table ram read in the loop,
// plus an idle state that takes the item and starts the first read, and a fill state for the tail
// after reset the table is built, a read and a write state per entry, with in_ready low
// in_ready is high only while idle; the finished beat sits in the output register,
// so the next item is taken while it waits on out_ready
module combination_rank_to_pattern (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [crp_pkg::CNT_W-1:0]  count_a,
	input  logic [crp_pkg::CNT_W-1:0]  count_b,
	input  logic [crp_pkg::RANK_W-1:0] rank,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [crp_pkg::PAT_W-1:0]  pattern,
	output logic [crp_pkg::CNT_W-1:0]  length,
	output logic                       too_long
);

	crp_pkg::state_t state_q, state_d;

	logic [crp_pkg::CNT_W-1:0]  a_q;
	logic [crp_pkg::CNT_W-1:0]  b_q;
	logic [crp_pkg::RANK_W-1:0] k_q;
	logic [crp_pkg::IDX_W-1:0]  pos_q;
	logic [crp_pkg::PAT_W-1:0]  pat_q;
	logic [crp_pkg::CNT_W-1:0]  total_q;
	logic                       too_long_q;

	logic                       out_valid_q;
	logic [crp_pkg::PAT_W-1:0]  pattern_q;
	logic [crp_pkg::CNT_W-1:0]  length_q;
	logic                       too_long_out_q;

	logic                       table_ready;
	logic [crp_pkg::ADDR_W-1:0] lookup_addr;
	logic [crp_pkg::PAT_W-1:0]  lookup_data;

	logic                       accept;
	logic                       load_out;
	logic                       out_free;
	logic [crp_pkg::CNT_W:0]    sum_in;
	logic                       sum_over;
	logic                       take_a;
	logic [crp_pkg::CNT_W-1:0]  a_nxt;
	logic [crp_pkg::CNT_W-1:0]  b_nxt;
	logic [crp_pkg::RANK_W-1:0] k_nxt;
	logic [crp_pkg::PAT_W-1:0]  pat_nxt;
	logic                       loop_done;
	logic [crp_pkg::PAT_W-1:0]  fill_mask;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign sum_in   = {1'b0, count_a} + {1'b0, count_b};
	assign sum_over = sum_in > (crp_pkg::CNT_W + 1)'(crp_pkg::MAX_LENGTH);

	// one compare and subtract step
	assign take_a    = {1'b0, k_q} <= lookup_data;
	assign a_nxt     = take_a ? a_q - crp_pkg::CNT_W'(1) : a_q;
	assign b_nxt     = take_a ? b_q : b_q - crp_pkg::CNT_W'(1);
	assign k_nxt     = take_a ? k_q : k_q - lookup_data[crp_pkg::RANK_W-1:0];
	assign pat_nxt   = take_a ? pat_q : pat_q | (crp_pkg::PAT_W'(1) << pos_q);
	assign loop_done = (a_nxt == '0) || (b_nxt == '0);

	// remaining b symbols occupy the top of the pattern
	assign fill_mask = crp_pkg::low_mask(total_q) & ~crp_pkg::low_mask(total_q - b_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			crp_pkg::ST_IDLE: begin
				if (accept) begin
					if (sum_over || count_a == '0 || count_b == '0) begin
						state_d = crp_pkg::ST_FILL;
					end else begin
						state_d = crp_pkg::ST_RUN;
					end
				end
			end
			crp_pkg::ST_RUN: begin
				if (loop_done) begin
					state_d = crp_pkg::ST_FILL;
				end
			end
			crp_pkg::ST_FILL: begin
				if (out_free) begin
					state_d = crp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crp_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		load_out    = 1'b0;
		lookup_addr = crp_pkg::binom_addr(a_nxt, b_nxt);
		unique case (state_q)
			crp_pkg::ST_IDLE: begin
				in_ready    = table_ready;
				lookup_addr = crp_pkg::binom_addr(count_a, count_b);
			end
			crp_pkg::ST_RUN: begin
				lookup_addr = crp_pkg::binom_addr(a_nxt, b_nxt);
			end
			crp_pkg::ST_FILL: begin
				load_out = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= crp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= '0;
			pat_q <= '0;
			k_q   <= rank;
			if (sum_over) begin
				a_q        <= '0;
				b_q        <= '0;
				total_q    <= '0;
				too_long_q <= 1'b1;
			end else begin
				a_q        <= count_a;
				b_q        <= count_b;
				total_q    <= sum_in[crp_pkg::CNT_W-1:0];
				too_long_q <= 1'b0;
			end
		end else if (state_q == crp_pkg::ST_RUN) begin
			a_q   <= a_nxt;
			b_q   <= b_nxt;
			k_q   <= k_nxt;
			pat_q <= pat_nxt;
			pos_q <= pos_q + crp_pkg::IDX_W'(1);
		end
		if (load_out) begin
			pattern_q      <= pat_q | fill_mask;
			length_q       <= total_q;
			too_long_out_q <= too_long_q;
		end
	end

	crp_table u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_addr(lookup_addr),
		.lookup_data(lookup_data),
		.table_ready(table_ready)
	);

	assign out_valid = out_valid_q;
	assign pattern   = pattern_q;
	assign length    = length_q;
	assign too_long  = too_long_out_q;

endmodule

[rtl/crp_checker.sv]
// port checker for the combination rank to pattern block, bound to the top level
// depends on crp_pkg and combination_rank_to_pattern_assert.svh
`include "combination_rank_to_pattern_assert.svh"

module crp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [crp_pkg::PAT_W-1:0]  pattern,
	input logic [crp_pkg::CNT_W-1:0]  length,
	input logic                       too_long
);

	// overlong counts give an empty beat
	`CRP_ASSERT_SAME(a_too_long_empty, out_valid && too_long, pattern == '0 && length == '0)
	// no symbol beyond the length
	`CRP_ASSERT_SAME(a_pattern_in_length, out_valid, (pattern >> length) == '0)
	// ones never outnumber the symbols
	`CRP_ASSERT_SAME(a_ones_fit, out_valid, $countones(pattern) <= length)
	// busy in the cycle after an input beat
	`CRP_ASSERT_NEXT(a_busy_after_beat, in_valid && in_ready, !in_ready)
	// stalled output beat holds
	`CRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(pattern) && $stable(length) && $stable(too_long))

endmodule

bind combination_rank_to_pattern crp_checker u_crp_checker (.*);

[tb/combination_rank_to_pattern_tb.sv]
// self-checking testbench for combination_rank_to_pattern: directed table, then random items
// checks every result beat against a local unranking predictor; depends on crp_pkg and the rtl
module combination_rank_to_pattern_tb;

	localparam int WATCHDOG_CYCLES = 20000;
	localparam int RANDOM_ITEMS    = 925;
	localparam int QUIET_FROM      = 780;
	localparam int HOLD_AT_BEAT    = 300;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 80;
	localparam int DIRECTED_ROWS   = 25;
	localparam int EXPECT_DEPTH    = DIRECTED_ROWS + RANDOM_ITEMS;

	typedef struct packed {
		logic [crp_pkg::PAT_W-1:0] pattern;
		logic [crp_pkg::CNT_W-1:0] length;
		logic                      too_long;
	} arrangement_t;

	typedef struct packed {
		logic                       known;
		logic [crp_pkg::CNT_W-1:0]  a;
		logic [crp_pkg::CNT_W-1:0]  b;
		logic [crp_pkg::RANK_W-1:0] k;
		arrangement_t               res;
	} stim_row_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic [crp_pkg::CNT_W-1:0]  count_a   = '0;
	logic [crp_pkg::CNT_W-1:0]  count_b   = '0;
	logic [crp_pkg::RANK_W-1:0] rank      = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [crp_pkg::PAT_W-1:0]  pattern;
	logic [crp_pkg::CNT_W-1:0]  length;
	logic                       too_long;

	logic [63:0]         binom [0:crp_pkg::MAX_LENGTH][0:crp_pkg::MAX_LENGTH];
	arrangement_t        expected_fifo [EXPECT_DEPTH];
	int                  exp_wr          = 0;
	int                  exp_rd          = 0;
	int                  mismatches      = 0;
	int                  rank_beats_in   = 0;
	int                  arrangements_out = 0;
	int                  overlong_out    = 0;
	int                  idle_cycles     = 0;
	int                  hold_left       = 0;
	int                  ready_gap_left  = 0;
	bit                  hold_done       = 1'b0;
	bit                  quiet           = 1'b0;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{1'b1, 7'd0,   7'd0,   63'd1, '{64'd0, 7'd0, 1'b0}},
		'{1'b1, 7'd0,   7'd0,   {63{1'b1}}, '{64'd0, 7'd0, 1'b0}},
		'{1'b1, 7'd1,   7'd0,   63'd1, '{64'd0, 7'd1, 1'b0}},
		'{1'b1, 7'd0,   7'd1,   63'd1, '{64'd1, 7'd1, 1'b0}},
		'{1'b1, 7'd1,   7'd1,   63'd1, '{64'd2, 7'd2, 1'b0}},
		'{1'b1, 7'd1,   7'd1,   63'd2, '{64'd1, 7'd2, 1'b0}},
		'{1'b1, 7'd1,   7'd1,   63'd0, '{64'd2, 7'd2, 1'b0}},
		'{1'b1, 7'd1,   7'd1,   63'd3, '{64'd1, 7'd2, 1'b0}},
		'{1'b1, 7'd2,   7'd2,   63'd1, '{64'd12, 7'd4, 1'b0}},
		'{1'b1, 7'd2,   7'd2,   63'd6, '{64'd3, 7'd4, 1'b0}},
		'{1'b1, 7'd64,  7'd0,   63'd1, '{64'd0, 7'd64, 1'b0}},
		'{1'b1, 7'd0,   7'd64,  63'd1, '{{64{1'b1}}, 7'd64, 1'b0}},
		'{1'b1, 7'd63,  7'd1,   63'd64, '{64'd1, 7'd64, 1'b0}},
		'{1'b1, 7'd1,   7'd63,  63'd1, '{64'hFFFF_FFFF_FFFF_FFFE, 7'd64, 1'b0}},
		'{1'b1, 7'd32,  7'd32,  63'd0, '{64'hFFFF_FFFF_0000_0000, 7'd64, 1'b0}},
		'{1'b1, 7'd32,  7'd32,  {63{1'b1}}, '{64'h0000_0000_FFFF_FFFF, 7'd64, 1'b0}},
		'{1'b1, 7'd65,  7'd0,   63'd1, '{64'd0, 7'd0, 1'b1}},
		'{1'b1, 7'd0,   7'd65,  63'd1, '{64'd0, 7'd0, 1'b1}},
		'{1'b1, 7'd64,  7'd1,   63'd1, '{64'd0, 7'd0, 1'b1}},
		'{1'b1, 7'd127, 7'd127, {63{1'b1}}, '{64'd0, 7'd0, 1'b1}},
		'{1'b0, 7'd10,  7'd7,   63'd12345, '{64'd0, 7'd0, 1'b0}},
		'{1'b0, 7'd32,  7'd32,  63'd1832624140942590534, '{64'd0, 7'd0, 1'b0}},
		'{1'b0, 7'd20,  7'd44,  63'h1234_5678_9ABC_DEF0, '{64'd0, 7'd0, 1'b0}},
		'{1'b0, 7'd5,   7'd9,   63'd1000, '{64'd0, 7'd0, 1'b0}},
		'{1'b0, 7'd40,  7'd24,  63'h0000_0F00_0000_0001, '{64'd0, 7'd0, 1'b0}}
	};

	combination_rank_to_pattern dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.count_a   (count_a),
		.count_b   (count_b),
		.rank      (rank),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pattern   (pattern),
		.length    (length),
		.too_long  (too_long)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic arrangement_t unrank_pattern(input logic [crp_pkg::CNT_W-1:0] a_in,
		input logic [crp_pkg::CNT_W-1:0] b_in, input logic [crp_pkg::RANK_W-1:0] k_in);
		arrangement_t r;
		int a;
		int b;
		int pos;
		logic [63:0] k;
		logic [63:0] w;
		r = '0;
		a = a_in;
		b = b_in;
		k = {1'b0, k_in};
		pos = 0;
		if (a + b > crp_pkg::MAX_LENGTH) begin
			r.too_long = 1'b1;
			return r;
		end
		while (a != 0 && b != 0) begin
			w = binom[a + b - 1][a - 1];
			if (k <= w) begin
				a--;
			end else begin
				r.pattern[pos] = 1'b1;
				b--;
				k = k - w;
			end
			pos++;
		end
		pos += a;
		while (b != 0) begin
			r.pattern[pos] = 1'b1;
			pos++;
			b--;
		end
		r.length = a_in + b_in;
		return r;
	endfunction

	task automatic expect_result(input arrangement_t r);
		expected_fifo[exp_wr] = r;
		exp_wr++;
	endtask

	task automatic offer_beat(input logic [crp_pkg::CNT_W-1:0] a,
		input logic [crp_pkg::CNT_W-1:0] b, input logic [crp_pkg::RANK_W-1:0] k);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		count_a  <= a;
		count_b  <= b;
		rank     <= k;
		do @(posedge clk); while (!in_ready);
		rank_beats_in++;
	endtask

	// result channel: check each beat, then pick out_ready for the next cycle
	always @(posedge clk) begin
		arrangement_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (exp_wr == exp_rd) begin
					$display("%0t: unexpected beat: pattern %h length %0d too_long %0b",
						$time, pattern, length, too_long);
					mismatches++;
				end else begin
					want = expected_fifo[exp_rd];
					exp_rd++;
					arrangements_out++;
					if (too_long) overlong_out++;
					if (pattern !== want.pattern) begin
						$display("%0t: pattern mismatch: expected %h actual %h",
							$time, want.pattern, pattern);
						mismatches++;
					end
					if (length !== want.length) begin
						$display("%0t: length mismatch: expected %0d actual %0d",
							$time, want.length, length);
						mismatches++;
					end
					if (too_long !== want.too_long) begin
						$display("%0t: too_long mismatch: expected %0b actual %0b",
							$time, want.too_long, too_long);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && rank_beats_in >= HOLD_AT_BEAT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (ready_gap_left > 0) begin
				ready_gap_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				ready_gap_left = $urandom_range(1, 4) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$time, idle_cycles, exp_wr - exp_rd);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		logic [crp_pkg::CNT_W-1:0]  a;
		logic [crp_pkg::CNT_W-1:0]  b;
		logic [crp_pkg::RANK_W-1:0] k;
		logic [63:0]                c;
		int                         n;
		int                         sel;
		for (int i = 0; i <= crp_pkg::MAX_LENGTH; i++) begin
			for (int j = 0; j <= crp_pkg::MAX_LENGTH; j++) begin
				if (j > i) binom[i][j] = 64'd0;
				else if (j == 0 || j == i) binom[i][j] = 64'd1;
				else binom[i][j] = binom[i - 1][j - 1] + binom[i - 1][j];
			end
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			offer_beat(directed_rows[i].a, directed_rows[i].b, directed_rows[i].k);
			if (directed_rows[i].known) expect_result(directed_rows[i].res);
			else expect_result(unrank_pattern(directed_rows[i].a,
				directed_rows[i].b, directed_rows[i].k));
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= QUIET_FROM) quiet = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				a = crp_pkg::CNT_W'($urandom);
				b = crp_pkg::CNT_W'($urandom);
				k = crp_pkg::RANK_W'({$urandom, $urandom});
			end else begin
				sel = $urandom_range(0, 99);
				if (sel < 70) n = $urandom_range(0, 16);
				else if (sel < 90) n = $urandom_range(17, 48);
				else n = $urandom_range(49, crp_pkg::MAX_LENGTH);
				a = crp_pkg::CNT_W'($urandom_range(0, n));
				b = crp_pkg::CNT_W'(n - a);
				c = binom[n][a];
				sel = $urandom_range(0, 99);
				if (sel < 78) k = crp_pkg::RANK_W'(64'd1 + ({$urandom, $urandom} % c));
				else if (sel < 86) k = crp_pkg::RANK_W'({$urandom, $urandom});
				else if (sel < 90) k = '0;
				else if (sel < 95) k = crp_pkg::RANK_W'(c);
				else k = crp_pkg::RANK_W'(c + 64'd1 + 64'($urandom_range(0, 15)));
			end
			offer_beat(a, b, k);
			expect_result(unrank_pattern(a, b, k));
		end
		in_valid <= 1'b0;

		while (exp_wr != exp_rd) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items sent (%0d from the directed table), %0d results checked",
			rank_beats_in, DIRECTED_ROWS, arrangements_out);
		$display("%0d results flagged too long, one long output stall of %0d cycles",
			overlong_out, HOLD_CYCLES);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
